// ===== sv/mtpd_pkg.sv =====
`default_nettype none

package mtpd_pkg;

    // Packet type field in byte 3 bits 1:0.
    typedef enum logic [1:0] {
        PKT_STATUS = 2'd0,
        PKT_HEAD   = 2'd1,
        PKT_MOTION = 2'd2
    } pkt_type_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEAD   = 2'd1,
        KIND_MOTION = 2'd2
    } report_kind_t;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [1:0] {
        REG_Y_FLIP_MAX   = 2'd0,
        REG_WIDTH_SCALE  = 2'd1,
        REG_MOTION_WEIGHT = 2'd2
    } reg_index_t;

    localparam logic [11:0] Y_FLIP_MAX_RST    = 12'd1080;
    localparam logic [7:0]  WIDTH_SCALE_RST   = 8'd1;
    localparam logic [3:0]  MOTION_WEIGHT_RST = 4'd5;

    // Second slot code that means no second finger.
    localparam logic [2:0] NO_SECOND = 3'd5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;

    // Adds or subtracts a scaled delta and clamps to the 16-bit signed range.
    function automatic logic signed [15:0] add_sat(
        input logic signed [15:0] pos,
        input logic signed [12:0] delta,
        input logic               sub
    );
        logic signed [17:0] sum;
        sum = sub ? (18'(pos) - 18'(delta)) : (18'(pos) + 18'(delta));
        if (sum > 18'sd32767) begin
            add_sat = 16'sh7fff;
        end else if (sum < -18'sd32768) begin
            add_sat = 16'sh8000;
        end else begin
            add_sat = sum[15:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/multitouch_packet_decoder.sv =====
`default_nettype none

// Six-byte touchpad packet decoder. Each input beat carries one packet and
// yields at most one result beat: status packets report released slots,
// head packets load a slot's absolute position, motion packets move one or
// two slots by signed, weighted deltas with 16-bit saturation. Invalid slot
// ids and unknown packet types are dropped without a result. The packet is
// decoded and the per-slot position registers are updated in the cycle it
// is accepted, and the result lands in an output register, so the block
// takes one packet every clock cycle; the rate is set by that slot update,
// and a stalled output only holds the input while the output
// register is full and not being taken. Configuration registers sit on an
// APB port at byte addresses 0 (y flip maximum), 4 (finger width scale) and
// 8 (motion weight).
module multitouch_packet_decoder #(
    parameter int NUM_SLOTS = 5
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [7:0] pkt_byte0, [15:8] pkt_byte1, [23:16] pkt_byte2,
    // [31:24] pkt_byte3, [39:32] pkt_byte4, [47:40] pkt_byte5
    input  wire logic [47:0]  s_tdata,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [2:0] button_bits, [7:3] released_mask, [10:8] first_slot,
    // [26:11] first_x, [42:27] first_y, [50:43] pressure,
    // [54:51] trace_count, [66:55] touch_major, [69:67] second_slot,
    // [85:70] second_x, [101:86] second_y, [103:102] zero
    output logic [103:0]      m_tdata,
    // [1:0] report_kind
    output logic [1:0]        m_tuser,

    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [2:0] SLOT_LIMIT = 3'(NUM_SLOTS);

    // Configuration registers.
    logic [11:0] y_flip_max_reg;
    logic [7:0]  width_scale_reg;
    logic [3:0]  motion_weight_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_flip_max_reg    <= mtpd_pkg::Y_FLIP_MAX_RST;
            width_scale_reg   <= mtpd_pkg::WIDTH_SCALE_RST;
            motion_weight_reg <= mtpd_pkg::MOTION_WEIGHT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                mtpd_pkg::REG_Y_FLIP_MAX:    y_flip_max_reg    <= pwdata[11:0];
                mtpd_pkg::REG_WIDTH_SCALE:   width_scale_reg   <= pwdata[7:0];
                mtpd_pkg::REG_MOTION_WEIGHT: motion_weight_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mtpd_pkg::REG_Y_FLIP_MAX:    prdata = {20'd0, y_flip_max_reg};
            mtpd_pkg::REG_WIDTH_SCALE:   prdata = {24'd0, width_scale_reg};
            mtpd_pkg::REG_MOTION_WEIGHT: prdata = {28'd0, motion_weight_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Packet fields.
    logic [7:0] b0, b1, b2, b3, b4, b5;
    logic [1:0] pkt_type;
    logic [2:0] id3, id0;

    assign b0 = s_tdata[7:0];
    assign b1 = s_tdata[15:8];
    assign b2 = s_tdata[23:16];
    assign b3 = s_tdata[31:24];
    assign b4 = s_tdata[39:32];
    assign b5 = s_tdata[47:40];

    assign pkt_type = b3[1:0];
    assign id3      = b3[7:5];
    assign id0      = b0[7:5];

    logic is_status, is_head, is_motion, has_second, produce;
    logic [2:0] first_idx, second_idx;

    assign has_second = (id3 != 3'd0);
    assign is_status  = (pkt_type == mtpd_pkg::PKT_STATUS);
    assign is_head    = (pkt_type == mtpd_pkg::PKT_HEAD) && has_second
                        && (id3 <= SLOT_LIMIT);
    assign is_motion  = (pkt_type == mtpd_pkg::PKT_MOTION)
                        && (id0 != 3'd0) && (id0 <= SLOT_LIMIT)
                        && (!has_second || (id3 <= SLOT_LIMIT));
    assign produce    = is_status || is_head || is_motion;

    assign first_idx  = is_head ? (id3 - 3'd1) : (id0 - 3'd1);
    assign second_idx = id3 - 3'd1;

    // Head packet values.
    logic signed [15:0] head_x, head_y;
    logic [7:0]         pressure;
    logic [3:0]         trace_count;
    logic [11:0]        touch_major;

    assign head_x      = {4'd0, b1[3:0], b2};
    assign head_y      = $signed({4'd0, y_flip_max_reg}) - $signed({4'd0, b4[3:0], b5});
    assign pressure    = {b1[7:4], b4[7:4]};
    assign trace_count = b0[7:4];
    assign touch_major = 12'(trace_count * width_scale_reg);

    // Scaled motion deltas.
    logic [3:0]         weight;
    logic signed [12:0] dx1, dy1, dx2, dy2;

    assign weight = b0[4] ? motion_weight_reg : 4'd1;
    assign dx1    = $signed(b1) * $signed({1'b0, weight});
    assign dy1    = $signed(b2) * $signed({1'b0, weight});
    assign dx2    = $signed(b4) * $signed({1'b0, weight});
    assign dy2    = $signed(b5) * $signed({1'b0, weight});

    // Status release mask: a clear presence bit means the slot is lifted.
    logic [4:0] released_mask;

    always_comb begin
        released_mask = 5'd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            released_mask[i] = ~b1[i];
        end
    end

    // Slot position registers, one update lane per slot.
    logic signed [15:0] slot_x_reg [NUM_SLOTS];
    logic signed [15:0] slot_y_reg [NUM_SLOTS];
    logic signed [15:0] mid_x [NUM_SLOTS];
    logic signed [15:0] mid_y [NUM_SLOTS];
    logic signed [15:0] fin_x [NUM_SLOTS];
    logic signed [15:0] fin_y [NUM_SLOTS];
    logic               sel_first  [NUM_SLOTS];
    logic               sel_second [NUM_SLOTS];

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
        assign sel_first[g]  = (is_head || is_motion) && (first_idx == 3'(g));
        assign sel_second[g] = is_motion && has_second && (second_idx == 3'(g));

        // The second finger may name the same slot as the first; it then
        // starts from the position the first finger already moved to.
        always_comb begin
            mid_x[g] = slot_x_reg[g];
            mid_y[g] = slot_y_reg[g];
            if (sel_first[g]) begin
                if (is_head) begin
                    mid_x[g] = head_x;
                    mid_y[g] = head_y;
                end else begin
                    mid_x[g] = mtpd_pkg::add_sat(slot_x_reg[g], dx1, 1'b0);
                    mid_y[g] = mtpd_pkg::add_sat(slot_y_reg[g], dy1, 1'b1);
                end
            end
            fin_x[g] = mid_x[g];
            fin_y[g] = mid_y[g];
            if (sel_second[g]) begin
                fin_x[g] = mtpd_pkg::add_sat(mid_x[g], dx2, 1'b0);
                fin_y[g] = mtpd_pkg::add_sat(mid_y[g], dy2, 1'b1);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                slot_x_reg[g] <= 16'sd0;
                slot_y_reg[g] <= 16'sd0;
            end else if (s_tvalid && s_tready) begin
                slot_x_reg[g] <= fin_x[g];
                slot_y_reg[g] <= fin_y[g];
            end
        end
    end

    // Pick the updated positions of the addressed slots.
    logic signed [15:0] first_x, first_y, second_x, second_y;

    always_comb begin
        first_x  = 16'sd0;
        first_y  = 16'sd0;
        second_x = 16'sd0;
        second_y = 16'sd0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sel_first[i]) begin
                first_x = first_x | mid_x[i];
                first_y = first_y | mid_y[i];
            end
            if (sel_second[i]) begin
                second_x = second_x | fin_x[i];
                second_y = second_y | fin_y[i];
            end
        end
    end

    // Result assembly.
    logic [1:0]   kind_next;
    logic [103:0] data_next;

    always_comb begin
        kind_next = mtpd_pkg::KIND_STATUS;
        data_next = '0;
        data_next[2:0] = b0[2:0];
        data_next[69:67] = mtpd_pkg::NO_SECOND;
        if (is_status) begin
            data_next[7:3] = released_mask;
        end else if (is_head) begin
            kind_next          = mtpd_pkg::KIND_HEAD;
            data_next[10:8]    = first_idx;
            data_next[26:11]   = first_x;
            data_next[42:27]   = first_y;
            data_next[50:43]   = pressure;
            data_next[54:51]   = trace_count;
            data_next[66:55]   = touch_major;
        end else begin
            kind_next          = mtpd_pkg::KIND_MOTION;
            data_next[10:8]    = first_idx;
            data_next[26:11]   = first_x;
            data_next[42:27]   = first_y;
            if (has_second) begin
                data_next[69:67]  = second_idx;
                data_next[85:70]  = second_x;
                data_next[101:86] = second_y;
            end
        end
    end

    // Output register: loads whenever it is empty or being drained.
    logic         m_tvalid_reg;
    logic         m_tvalid_next;
    logic [103:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    assign s_tready      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = s_tready ? (s_tvalid && produce) : m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            m_tdata_reg <= data_next;
            m_tuser_reg <= kind_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
